[sv/vrra_pkg.sv]
// Package for the variable record ring allocator: widths, codes, transaction
// structs, sequencer states and the shared arithmetic unit's request/response.
// No dependencies.
package vrra_pkg;

  // Built depth of the header store and derived widths
  localparam int DEPTH  = 4096;
  localparam int ADDR_W = 12;
  localparam int POS_W  = 12;
  localparam int SIZE_W = 13;
  localparam int LEN_W  = 12;
  localparam int HDR_W  = 13;

  // Ring size limits applied on a size register write
  localparam logic [SIZE_W-1:0] MIN_SIZE   = 13'd4;
  localparam logic [SIZE_W-1:0] MAX_SIZE   = 13'd4096;
  localparam logic [SIZE_W-1:0] RESET_SIZE = 13'd4096;

  // Record header plus the skip header kept in reserve
  localparam logic [SIZE_W-1:0] EXTRA_UNITS = 13'd2;

  // Header layout: ready flag on top, payload units below
  localparam logic [HDR_W-1:0] READY_MASK = 13'h1000;
  localparam logic [HDR_W-1:0] SKIP_HDR   = 13'h1000;

  typedef enum logic [1:0] {
    REQ_RESERVE = 2'd0,
    REQ_COMMIT  = 2'd1,
    REQ_PEEK    = 2'd2,
    REQ_RELEASE = 2'd3
  } req_type_t;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_NO_SPACE = 2'd1,
    ST_NOT_HEAD = 2'd2,
    ST_BAD_SIZE = 2'd3
  } status_t;

  typedef struct packed {
    req_type_t        req_type;
    logic [LEN_W-1:0] req_size;
    logic [POS_W-1:0] handle;
  } in_item_t;

  typedef struct packed {
    status_t          status;
    logic [POS_W-1:0] offset;
    logic [LEN_W-1:0] length;
  } out_item_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_RES_BASE,
    S_RES_FREE,
    S_RES_END,
    S_CMT_POS,
    S_CMT_RD,
    S_CMT_WR,
    S_PK_CHK,
    S_PK_HDR,
    S_REL_CHK,
    S_REL_HDR,
    S_REL_ADV,
    S_DONE
  } state_t;

  // Shared unit: sum = a +/- b (+ carry in), then compare sum against c
  typedef struct packed {
    logic [SIZE_W-1:0] a;
    logic [SIZE_W-1:0] b;
    logic [SIZE_W-1:0] c;
    logic              sub;
    logic              cin;
  } alu_req_t;

  typedef struct packed {
    logic [SIZE_W-1:0] sum;
    logic              gt;
    logic              eq;
  } alu_rsp_t;

endpackage

[sv/vrra_ram.sv]
// Generic simple dual-port RAM: one write port, one read port with
// registered read data. No dependencies.
module vrra_ram #(
  parameter int WIDTH = 13,
  parameter int DEPTH = 4096
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port and registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

[sv/vrra_alu.sv]
// Shared add/subtract and compare unit of the ring allocator sequencer.
// Depends on vrra_pkg.
module vrra_alu (
  input  vrra_pkg::alu_req_t req,
  output vrra_pkg::alu_rsp_t rsp
);
  import vrra_pkg::*;

  logic [SIZE_W-1:0] b_eff;
  logic [SIZE_W-1:0] carry;
  logic [SIZE_W-1:0] sum;

  // Invert b for subtract; the carry in completes the two's complement
  assign b_eff = req.sub ? ~req.b : req.b;
  assign carry = {{(SIZE_W-1){1'b0}}, req.sub | req.cin};
  assign sum   = req.a + b_eff + carry;

  // Compare the result against the third operand
  assign rsp.sum = sum;
  assign rsp.gt  = sum > req.c;
  assign rsp.eq  = sum == req.c;

endmodule

[sv/variable_record_ring_allocator.sv]
// Variable record ring allocator: sequencer, offsets and header store.
// Depends on vrra_pkg, vrra_alu and vrra_ram.
//
// Usage:
//   Input channel (in_valid/in_stall/in_data) carries one request per
//   transaction: reserve, commit, peek or release. Result channel
//   (out_valid/out_stall/out_data) returns exactly one result per request.
//   cfg_we/cfg_wdata write the ring size (clamped to 4..4096) and empty the
//   ring; write it only while no request is in flight.
// Timing:
//   A request is worked by a small sequencer around one shared add/compare
//   unit and the header RAM, whose read data is registered and arrives in
//   the cycle after the address. The sequencer returns to idle before the
//   next request is taken, so requests do not overlap. in_stall is high
//   whenever the sequencer is busy.
// Reset:
//   rst_n (synchronous) empties the ring and sets the size to 4096. Header
//   contents are not cleared.
// Backpressure:
//   A result sits in an output register. While out_stall holds it, the next
//   request is still accepted and worked; its result waits in the sequencer
//   until the output register frees.
module variable_record_ring_allocator (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_valid,
  output logic                            in_stall,
  input  vrra_pkg::in_item_t              in_data,
  output logic                            out_valid,
  input  logic                            out_stall,
  output vrra_pkg::out_item_t             out_data,
  input  logic                            cfg_we,
  input  logic [vrra_pkg::SIZE_W-1:0]     cfg_wdata
);
  import vrra_pkg::*;

  state_t            state_r, state_nxt;
  in_item_t          item_r;
  logic [SIZE_W-1:0] size_r;
  logic [POS_W-1:0]  wr_pos_r, wr_pos_nxt;
  logic [POS_W-1:0]  rd_pos_r, rd_pos_nxt;
  logic [SIZE_W-1:0] tmp_r, tmp_nxt;
  logic [HDR_W-1:0]  hdr_r, hdr_nxt;
  logic              pass_r, pass_nxt;
  out_item_t         res_r, res_nxt;
  out_item_t         out_r;
  logic              out_valid_r;

  alu_req_t          alu_req;
  alu_rsp_t          alu_rsp;

  logic              ram_we;
  logic [ADDR_W-1:0] ram_waddr;
  logic [HDR_W-1:0]  ram_wdata;
  logic [ADDR_W-1:0] ram_raddr;
  logic [HDR_W-1:0]  ram_rdata;

  logic              accept;
  logic              out_free;
  logic              ring_empty;
  logic              hdr_ready;
  logic              hdr_skip;
  logic [LEN_W-1:0]  hdr_len;
  logic [SIZE_W-1:0] cfg_size;
  logic [POS_W-1:0]  wr_offset;

  vrra_alu u_alu (
    .req (alu_req),
    .rsp (alu_rsp)
  );

  vrra_ram #(
    .WIDTH (HDR_W),
    .DEPTH (DEPTH)
  ) u_hdr_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  assign accept     = in_valid && !in_stall;
  assign in_stall   = state_r != S_IDLE;
  assign out_free   = !out_valid_r || !out_stall;
  assign ring_empty = rd_pos_r == wr_pos_r;
  assign hdr_ready  = ram_rdata[HDR_W-1];
  assign hdr_len    = ram_rdata[LEN_W-1:0];
  assign hdr_skip   = hdr_ready && (hdr_len == '0);
  assign wr_offset  = wr_pos_r + 12'd1;

  // Clamp the written ring size to the supported range
  always_comb begin
    if (cfg_wdata < MIN_SIZE) begin
      cfg_size = MIN_SIZE;
    end else if (cfg_wdata > MAX_SIZE) begin
      cfg_size = MAX_SIZE;
    end else begin
      cfg_size = cfg_wdata;
    end
  end

  // Next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          case (in_data.req_type)
            REQ_RESERVE: state_nxt = S_RES_BASE;
            REQ_COMMIT:  state_nxt = S_CMT_POS;
            REQ_PEEK:    state_nxt = S_PK_CHK;
            REQ_RELEASE: state_nxt = S_REL_CHK;
            default:     state_nxt = S_IDLE;
          endcase
        end
      end
      S_RES_BASE: state_nxt = (item_r.req_size == '0) ? S_DONE : S_RES_FREE;
      S_RES_FREE: state_nxt = alu_rsp.gt ? S_RES_END : S_DONE;
      S_RES_END:  state_nxt = alu_rsp.gt ? S_RES_BASE : S_DONE;
      S_CMT_POS: begin
        if (item_r.handle != '0 && !(alu_rsp.gt || alu_rsp.eq)) begin
          state_nxt = S_CMT_RD;
        end else begin
          state_nxt = S_DONE;
        end
      end
      S_CMT_RD:   state_nxt = S_CMT_WR;
      S_CMT_WR:   state_nxt = S_DONE;
      S_PK_CHK:   state_nxt = ring_empty ? S_DONE : S_PK_HDR;
      S_PK_HDR: begin
        if (hdr_skip && !pass_r) begin
          state_nxt = S_PK_CHK;
        end else begin
          state_nxt = S_DONE;
        end
      end
      S_REL_CHK:  state_nxt = ring_empty ? S_DONE : S_REL_HDR;
      S_REL_HDR:  state_nxt = (hdr_skip || !alu_rsp.eq) ? S_DONE : S_REL_ADV;
      S_REL_ADV:  state_nxt = S_DONE;
      S_DONE:     state_nxt = out_free ? S_IDLE : S_DONE;
      default:    state_nxt = S_IDLE;
    endcase
  end

  // Datapath control: shared unit operands, header RAM access, offsets
  always_comb begin
    alu_req    = '0;
    ram_we     = 1'b0;
    ram_waddr  = wr_pos_r;
    ram_wdata  = '0;
    ram_raddr  = rd_pos_r;
    wr_pos_nxt = wr_pos_r;
    rd_pos_nxt = rd_pos_r;
    tmp_nxt    = tmp_r;
    hdr_nxt    = hdr_r;
    pass_nxt   = pass_r;
    res_nxt    = res_r;
    case (state_r)
      S_IDLE: begin
        if (accept) begin
          res_nxt  = '0;
          pass_nxt = 1'b0;
        end
      end
      // Base of the free space: read offset, plus the ring size when the
      // write offset is at or past it
      S_RES_BASE: begin
        alu_req.a = {1'b0, rd_pos_r};
        alu_req.b = (wr_pos_r >= rd_pos_r) ? size_r : '0;
        tmp_nxt   = alu_rsp.sum;
        if (item_r.req_size == '0) begin
          res_nxt.status = ST_BAD_SIZE;
        end
      end
      // Free space minus write offset must exceed payload plus two headers
      S_RES_FREE: begin
        alu_req.a   = tmp_r;
        alu_req.b   = {1'b0, wr_pos_r};
        alu_req.sub = 1'b1;
        alu_req.c   = {1'b0, item_r.req_size} + EXTRA_UNITS;
        if (!alu_rsp.gt) begin
          res_nxt.status = ST_NO_SPACE;
        end
      end
      // Place the record, or drop a skip header and wrap to the start
      S_RES_END: begin
        alu_req.a   = {1'b0, wr_pos_r};
        alu_req.b   = {1'b0, item_r.req_size};
        alu_req.cin = 1'b1;
        alu_req.c   = size_r;
        ram_we      = 1'b1;
        if (alu_rsp.gt) begin
          ram_wdata  = SKIP_HDR;
          wr_pos_nxt = '0;
        end else begin
          ram_wdata      = {1'b0, item_r.req_size};
          res_nxt.offset = wr_offset;
          wr_pos_nxt     = alu_rsp.eq ? '0 : alu_rsp.sum[POS_W-1:0];
        end
      end
      // Header position is handle minus one; it must lie inside the ring
      S_CMT_POS: begin
        alu_req.a   = {1'b0, item_r.handle};
        alu_req.b   = 13'd1;
        alu_req.sub = 1'b1;
        alu_req.c   = size_r;
        tmp_nxt     = alu_rsp.sum;
      end
      S_CMT_RD: begin
        ram_raddr = tmp_r[ADDR_W-1:0];
      end
      // Set the ready flag, keeping the length
      S_CMT_WR: begin
        ram_we    = 1'b1;
        ram_waddr = tmp_r[ADDR_W-1:0];
        ram_wdata = ram_rdata | READY_MASK;
      end
      S_PK_CHK: begin
        if (ring_empty) begin
          res_nxt.status = ST_NO_SPACE;
        end
      end
      // Pass over a skip header once; report a ready record, or no space if not ready
      S_PK_HDR: begin
        alu_req.a   = {1'b0, rd_pos_r};
        alu_req.cin = 1'b1;
        if (!hdr_ready) begin
          res_nxt.status = ST_NO_SPACE;
        end else if (hdr_skip) begin
          rd_pos_nxt = '0;
          pass_nxt   = 1'b1;
          if (pass_r) begin
            res_nxt.status = ST_NO_SPACE;
          end
        end else begin
          res_nxt.offset = alu_rsp.sum[POS_W-1:0];
          res_nxt.length = hdr_len;
        end
      end
      S_REL_CHK: begin
        if (ring_empty) begin
          res_nxt.status = ST_NO_SPACE;
        end
      end
      // Handle must name the record at the read head
      S_REL_HDR: begin
        alu_req.a   = {1'b0, rd_pos_r};
        alu_req.cin = 1'b1;
        alu_req.c   = {1'b0, item_r.handle};
        hdr_nxt     = ram_rdata;
        if (hdr_skip || !alu_rsp.eq) begin
          res_nxt.status = ST_NOT_HEAD;
        end
      end
      // Advance the read head past header and payload, wrap at the end
      S_REL_ADV: begin
        alu_req.a   = {1'b0, rd_pos_r};
        alu_req.b   = {1'b0, hdr_r[LEN_W-1:0]};
        alu_req.cin = 1'b1;
        alu_req.c   = size_r;
        rd_pos_nxt  = (alu_rsp.gt || alu_rsp.eq) ? '0 : alu_rsp.sum[POS_W-1:0];
      end
      S_DONE: begin
      end
      default: begin
      end
    endcase
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      size_r      <= RESET_SIZE;
      wr_pos_r    <= '0;
      rd_pos_r    <= '0;
      pass_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      pass_r   <= pass_nxt;
      // Size write empties the ring
      if (cfg_we) begin
        size_r   <= cfg_size;
        wr_pos_r <= '0;
        rd_pos_r <= '0;
      end else begin
        wr_pos_r <= wr_pos_nxt;
        rd_pos_r <= rd_pos_nxt;
      end
      // Hand the result to the output register once it is free
      if (state_r == S_DONE && out_free) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    if (accept) begin
      item_r <= in_data;
    end
    tmp_r <= tmp_nxt;
    hdr_r <= hdr_nxt;
    res_r <= res_nxt;
    if (state_r == S_DONE && out_free) begin
      out_r <= res_r;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

endmodule
